[sv/tlpt_pkg.sv]
// shared constants, types and codes of the two-level page table engine
// no dependencies; used by tlpt_ctrl, the top level and the testbench
`timescale 1ns / 1ps
`default_nettype none

package tlpt_pkg;

    // table geometry
    localparam int DIR_ENTRIES   = 1024;
    localparam int TABLE_ENTRIES = 1024;
    localparam int TABLE_SLOTS   = 16;

    localparam int DIR_AW  = $clog2(DIR_ENTRIES);
    localparam int TBL_AW  = $clog2(TABLE_ENTRIES);
    localparam int SLOT_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W   = $clog2(TABLE_SLOTS + 1);
    localparam int DIR_W   = 1 + SLOT_W;
    localparam int LEAF_AW = SLOT_W + TBL_AW;
    localparam int LEAF_DEPTH = TABLE_SLOTS * TABLE_ENTRIES;
    localparam int CLR_W   = (DIR_AW > TBL_AW) ? DIR_AW : TBL_AW;

    localparam int ADDR_W  = 32;
    localparam int PAGE_W  = 12;
    localparam int FRAME_W = ADDR_W - PAGE_W;

    // operation codes
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_MAP    = 2'd0;
    localparam t_mode MODE_UNMAP  = 2'd1;
    localparam t_mode MODE_LOOKUP = 2'd2;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DIR,
        ST_CLEAR,
        ST_MAPW,
        ST_LEAF
    } t_state;

    // directory port request: present bit on top, slot number below
    typedef struct packed {
        logic              we;
        logic [DIR_AW-1:0] addr;
        logic [DIR_W-1:0]  wdata;
    } t_dir_req;

    typedef struct packed {
        logic               we;
        logic [LEAF_AW-1:0] addr;
        logic [ADDR_W-1:0]  wdata;
    } t_leaf_req;

endpackage

`default_nettype wire

[sv/tlpt_ram.sv]
// generic single-port synchronous ram, registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tlpt_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        r_rdata <= mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[sv/tlpt_ctrl.sv]
// sequencer of the page table engine: directory clear, walk, slot clear, result
// depends on tlpt_pkg; drives the directory and leaf ram ports
`timescale 1ns / 1ps
`default_nettype none

module tlpt_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    output logic                             o_busy,
    input  wire tlpt_pkg::t_mode             i_mode,
    input  wire logic [tlpt_pkg::ADDR_W-1:0] i_virt_addr,
    input  wire logic [tlpt_pkg::ADDR_W-1:0] i_phys_addr,
    input  wire logic [tlpt_pkg::PAGE_W-1:0] i_entry_flags,
    output tlpt_pkg::t_dir_req               o_dir_req,
    input  wire logic [tlpt_pkg::DIR_W-1:0]  i_dir_rdata,
    output tlpt_pkg::t_leaf_req              o_leaf_req,
    input  wire logic [tlpt_pkg::ADDR_W-1:0] i_leaf_rdata,
    output logic                             o_valid,
    output logic                             o_found,
    output logic [tlpt_pkg::ADDR_W-1:0]      o_mapped_addr,
    output logic                             o_status
);

    tlpt_pkg::t_state r_state, n_state;

    tlpt_pkg::t_mode                r_mode;
    logic [tlpt_pkg::ADDR_W-1:0]    r_va;
    logic [tlpt_pkg::FRAME_W-1:0]   r_frame;
    logic [tlpt_pkg::PAGE_W-1:0]    r_flags;

    logic [tlpt_pkg::CLR_W-1:0]     r_cnt, n_cnt;
    logic [tlpt_pkg::CNT_W-1:0]     r_used, n_used;
    logic [tlpt_pkg::SLOT_W-1:0]    r_slot, n_slot;

    logic                           r_valid, n_valid;
    logic                           r_found, n_found;
    logic [tlpt_pkg::ADDR_W-1:0]    r_addr, n_addr;
    logic                           r_status, n_status;

    logic                           accept;
    logic                           dir_present;
    logic [tlpt_pkg::SLOT_W-1:0]    dir_slot;
    logic [tlpt_pkg::SLOT_W-1:0]    new_slot;
    logic                           pool_full;
    logic [tlpt_pkg::DIR_AW-1:0]    di;
    logic [tlpt_pkg::TBL_AW-1:0]    ti;
    logic [tlpt_pkg::ADDR_W-1:0]    map_value;
    logic                           init_last;
    logic                           clear_last;

    assign accept      = i_start && (r_state == tlpt_pkg::ST_IDLE);
    assign dir_present = i_dir_rdata[tlpt_pkg::DIR_W-1];
    assign dir_slot    = i_dir_rdata[tlpt_pkg::SLOT_W-1:0];
    assign new_slot    = r_used[tlpt_pkg::SLOT_W-1:0];
    assign pool_full   = (r_used == tlpt_pkg::CNT_W'(tlpt_pkg::TABLE_SLOTS));
    assign di          = r_va[tlpt_pkg::ADDR_W-1 -: tlpt_pkg::DIR_AW];
    assign ti          = r_va[tlpt_pkg::PAGE_W +: tlpt_pkg::TBL_AW];
    assign map_value   = {r_frame, r_flags};
    assign init_last   = (r_cnt[tlpt_pkg::DIR_AW-1:0] == '1);
    assign clear_last  = (r_cnt[tlpt_pkg::TBL_AW-1:0] == '1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tlpt_pkg::ST_INIT: begin
                if (init_last) begin
                    n_state = tlpt_pkg::ST_IDLE;
                end
            end
            tlpt_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = tlpt_pkg::ST_DIR;
                end
            end
            tlpt_pkg::ST_DIR: begin
                n_state = tlpt_pkg::ST_IDLE;
                case (r_mode)
                    tlpt_pkg::MODE_MAP: begin
                        if (!dir_present && !pool_full) begin
                            n_state = tlpt_pkg::ST_CLEAR;
                        end
                    end
                    tlpt_pkg::MODE_LOOKUP: begin
                        if (dir_present) begin
                            n_state = tlpt_pkg::ST_LEAF;
                        end
                    end
                    default: n_state = tlpt_pkg::ST_IDLE;
                endcase
            end
            tlpt_pkg::ST_CLEAR: begin
                if (clear_last) begin
                    n_state = tlpt_pkg::ST_MAPW;
                end
            end
            tlpt_pkg::ST_MAPW: n_state = tlpt_pkg::ST_IDLE;
            tlpt_pkg::ST_LEAF: n_state = tlpt_pkg::ST_IDLE;
            default:           n_state = tlpt_pkg::ST_INIT;
        endcase
    end

    // memory requests and register updates
    always_comb begin
        o_dir_req        = '0;
        o_dir_req.addr   = di;
        o_leaf_req       = '0;
        o_leaf_req.addr  = {dir_slot, ti};
        n_cnt    = r_cnt;
        n_used   = r_used;
        n_slot   = r_slot;
        n_valid  = 1'b0;
        n_found  = 1'b0;
        n_addr   = '0;
        n_status = 1'b0;
        case (r_state)
            tlpt_pkg::ST_INIT: begin
                o_dir_req.we   = 1'b1;
                o_dir_req.addr = r_cnt[tlpt_pkg::DIR_AW-1:0];
                n_cnt          = r_cnt + tlpt_pkg::CLR_W'(1);
            end
            tlpt_pkg::ST_IDLE: begin
                o_dir_req.addr = i_virt_addr[tlpt_pkg::ADDR_W-1 -: tlpt_pkg::DIR_AW];
            end
            tlpt_pkg::ST_DIR: begin
                case (r_mode)
                    tlpt_pkg::MODE_MAP: begin
                        if (dir_present) begin
                            o_leaf_req.we    = 1'b1;
                            o_leaf_req.wdata = map_value;
                            n_valid          = 1'b1;
                        end else if (pool_full) begin
                            n_valid  = 1'b1;
                            n_status = 1'b1;
                        end else begin
                            o_dir_req.we    = 1'b1;
                            o_dir_req.wdata = {1'b1, new_slot};
                            n_slot = new_slot;
                            n_used = r_used + tlpt_pkg::CNT_W'(1);
                            n_cnt  = '0;
                        end
                    end
                    tlpt_pkg::MODE_UNMAP: begin
                        o_leaf_req.we = dir_present;
                        n_valid       = 1'b1;
                    end
                    tlpt_pkg::MODE_LOOKUP: begin
                        n_valid = !dir_present;
                    end
                    default: n_valid = 1'b1;
                endcase
            end
            tlpt_pkg::ST_CLEAR: begin
                o_leaf_req.we   = 1'b1;
                o_leaf_req.addr = {r_slot, r_cnt[tlpt_pkg::TBL_AW-1:0]};
                n_cnt           = r_cnt + tlpt_pkg::CLR_W'(1);
            end
            tlpt_pkg::ST_MAPW: begin
                o_leaf_req.we    = 1'b1;
                o_leaf_req.addr  = {r_slot, ti};
                o_leaf_req.wdata = map_value;
                n_valid          = 1'b1;
            end
            tlpt_pkg::ST_LEAF: begin
                n_valid = 1'b1;
                n_found = (i_leaf_rdata != '0);
                n_addr  = {i_leaf_rdata[tlpt_pkg::ADDR_W-1:tlpt_pkg::PAGE_W],
                           {tlpt_pkg::PAGE_W{1'b0}}};
            end
            default: n_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlpt_pkg::ST_INIT;
            r_cnt   <= '0;
            r_used  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_used  <= n_used;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_mode;
            r_va    <= i_virt_addr;
            r_frame <= i_phys_addr[tlpt_pkg::ADDR_W-1:tlpt_pkg::PAGE_W];
            r_flags <= i_entry_flags;
        end
        r_slot   <= n_slot;
        r_found  <= n_found;
        r_addr   <= n_addr;
        r_status <= n_status;
    end

    assign o_busy        = (r_state != tlpt_pkg::ST_IDLE);
    assign o_valid       = r_valid;
    assign o_found       = r_found;
    assign o_mapped_addr = r_addr;
    assign o_status      = r_status;

endmodule

`default_nettype wire

[sv/two_level_page_table_engine.sv]
// top level of the two-level page table engine
// depends on tlpt_pkg, tlpt_ram and tlpt_ctrl
`timescale 1ns / 1ps
`default_nettype none

// two-level 32-bit page table with map, unmap and lookup commands. a command
// is taken when start is high and busy is low; exactly one result follows,
// shown for a single cycle with o_valid high, and the receiver cannot stall
// it, so o_valid must be sampled every cycle. after reset the directory is
// swept to "not present", which keeps busy high while the sweep runs. work
// per transaction: a map into an existing leaf table, an unmap, a reserved
// mode command, a lookup whose directory entry is empty, or a map that
// finds the slot pool used up ends with the directory ram read; lookup of a
// present table does a directory read, then a leaf ram read; a map that
// allocates a new leaf table writes the directory entry, then clears the
// new slot one word per cycle through the leaf ram's single port and writes
// the entry. busy drops in the cycle o_valid is shown, so a new command may be
// started alongside a result. leaf table slots are handed out in order and
// never returned; once all are used a map that needs a new table returns
// o_status = 1 and changes nothing.

module two_level_page_table_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_mode,
    input  wire logic [31:0] i_virt_addr,
    input  wire logic [31:0] i_phys_addr,
    input  wire logic [11:0] i_entry_flags,
    output logic             o_valid,
    output logic             o_found,
    output logic [31:0]      o_mapped_addr,
    output logic             o_status
);

    // ram request buses from the sequencer
    tlpt_pkg::t_dir_req               dir_req;
    tlpt_pkg::t_leaf_req              leaf_req;
    logic [tlpt_pkg::DIR_W-1:0]       dir_rdata;
    logic [tlpt_pkg::ADDR_W-1:0]      leaf_rdata;

    // directory: present bit plus slot number per entry
    tlpt_ram #(
        .DEPTH  (tlpt_pkg::DIR_ENTRIES),
        .WIDTH  (tlpt_pkg::DIR_W),
        .ADDR_W (tlpt_pkg::DIR_AW)
    ) u_dir_ram (
        .i_clk   (i_clk),
        .i_we    (dir_req.we),
        .i_addr  (dir_req.addr),
        .i_wdata (dir_req.wdata),
        .o_rdata (dir_rdata)
    );

    // leaf tables: slot number selects the table, va[21:12] the entry
    tlpt_ram #(
        .DEPTH  (tlpt_pkg::LEAF_DEPTH),
        .WIDTH  (tlpt_pkg::ADDR_W),
        .ADDR_W (tlpt_pkg::LEAF_AW)
    ) u_leaf_ram (
        .i_clk   (i_clk),
        .i_we    (leaf_req.we),
        .i_addr  (leaf_req.addr),
        .i_wdata (leaf_req.wdata),
        .o_rdata (leaf_rdata)
    );

    // walk sequencer; every write lands before the next command's first read,
    // so no forwarding is needed
    tlpt_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_mode        (i_mode),
        .i_virt_addr   (i_virt_addr),
        .i_phys_addr   (i_phys_addr),
        .i_entry_flags (i_entry_flags),
        .o_dir_req     (dir_req),
        .i_dir_rdata   (dir_rdata),
        .o_leaf_req    (leaf_req),
        .i_leaf_rdata  (leaf_rdata),
        .o_valid       (o_valid),
        .o_found       (o_found),
        .o_mapped_addr (o_mapped_addr),
        .o_status      (o_status)
    );

endmodule

`default_nettype wire

[sv/tlpt_checker.sv]
// port-level checks of the page table engine and their bind to the top level
// depends only on the ports of two_level_page_table_engine
`timescale 1ns / 1ps
`default_nettype none

module tlpt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic        o_found,
    input wire logic [31:0] o_mapped_addr,
    input wire logic        o_status
);

    // an accepted transaction always makes the engine busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // results never come back to back
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // a result is only shown once the engine is free again
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while engine busy");

    // address is a page frame, and zero unless a lookup hit
    a_addr_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_mapped_addr[11:0] == 12'd0) &&
                     (o_found || (o_mapped_addr == 32'd0))))
        else $error("malformed mapped address");

    // a lookup hit and a map failure cannot share a result
    a_found_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> !o_status)
        else $error("found and failure status both set");

endmodule

bind two_level_page_table_engine tlpt_checker u_tlpt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_found       (o_found),
    .o_mapped_addr (o_mapped_addr),
    .o_status      (o_status)
);

`default_nettype wire

[dv/tb_top.sv]
// self-checking testbench for the two-level page table engine: directed and random
// map, unmap and lookup commands against an in-bench model of the table walk
// depends on tlpt_pkg and two_level_page_table_engine
`timescale 1ns / 1ps

module tb_top;

    // the fourth mode code has no meaning in the block and must return all zeros
    localparam tlpt_pkg::t_mode MODE_RESERVED = 2'd3;

    localparam int IDLE_PCT      = 22;
    localparam int RANDOM_ITEMS  = 750;
    localparam int DRAIN_EVERY   = 150;
    localparam int QUIET_FIRST   = 220;    // issue window with no sender gaps
    localparam int QUIET_LAST    = 420;
    localparam int TAIL_CYCLES   = 1100;   // longer than an allocating map
    localparam int DIR_POOL      = 24;     // more than the slot pool, to exhaust it
    localparam int LEAF_POOL     = 8;

    // one pending command; drain makes the sender wait for all results first
    typedef struct {
        tlpt_pkg::t_mode mode;
        logic [31:0]     va;
        logic [31:0]     pa;
        logic [11:0]     flags;
        bit              drain;
    } t_walk_cmd;

    typedef struct packed {
        logic        found;
        logic [31:0] mapped_addr;
        logic        status;
    } t_walk_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_mode = tlpt_pkg::MODE_LOOKUP;
    logic [31:0] i_virt_addr = '0;
    logic [31:0] i_phys_addr = '0;
    logic [11:0] i_entry_flags = '0;
    logic        o_valid;
    logic        o_found;
    logic [31:0] o_mapped_addr;
    logic        o_status;

    two_level_page_table_engine u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_virt_addr   (i_virt_addr),
        .i_phys_addr   (i_phys_addr),
        .i_entry_flags (i_entry_flags),
        .o_valid       (o_valid),
        .o_found       (o_found),
        .o_mapped_addr (o_mapped_addr),
        .o_status      (o_status)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // table model: directory, leaf pool and allocation count
    // ---------------------------------------------------------------
    bit           dir_present [tlpt_pkg::DIR_ENTRIES];
    int           dir_slot    [tlpt_pkg::DIR_ENTRIES];
    logic [31:0]  leaf_words  [tlpt_pkg::LEAF_DEPTH];
    int           slots_taken = 0;

    t_walk_cmd    cmd_q[$];
    t_walk_result walk_results_q[$];
    int           n_errors = 0;
    int           n_issued = 0;

    initial begin
        foreach (dir_present[i]) dir_present[i] = 1'b0;
        foreach (dir_slot[i]) dir_slot[i] = 0;
        foreach (leaf_words[i]) leaf_words[i] = '0;
    end

    // walk the table for one accepted command and update the model state
    function automatic t_walk_result walk_table(tlpt_pkg::t_mode m, logic [31:0] va,
                                                logic [31:0] pa, logic [11:0] fl);
        t_walk_result r;
        int           di;
        int           pos;
        logic [31:0]  e;
        r  = '0;
        di = int'(va[31:22]);
        case (m)
            tlpt_pkg::MODE_MAP: begin
                if (!dir_present[di]) begin
                    if (slots_taken >= tlpt_pkg::TABLE_SLOTS) begin
                        // pool exhausted: report it and leave everything alone
                        r.status = 1'b1;
                    end else begin
                        // fresh slot is wiped before use
                        for (int k = 0; k < tlpt_pkg::TABLE_ENTRIES; k++)
                            leaf_words[slots_taken * tlpt_pkg::TABLE_ENTRIES + k] = '0;
                        dir_slot[di]    = slots_taken;
                        dir_present[di] = 1'b1;
                        slots_taken++;
                    end
                end
                if (!r.status) begin
                    pos = dir_slot[di] * tlpt_pkg::TABLE_ENTRIES + int'(va[21:12]);
                    leaf_words[pos] = {pa[31:12], fl};
                end
            end
            tlpt_pkg::MODE_UNMAP: begin
                if (dir_present[di]) begin
                    pos = dir_slot[di] * tlpt_pkg::TABLE_ENTRIES + int'(va[21:12]);
                    leaf_words[pos] = '0;
                end
            end
            tlpt_pkg::MODE_LOOKUP: begin
                if (dir_present[di]) begin
                    pos = dir_slot[di] * tlpt_pkg::TABLE_ENTRIES + int'(va[21:12]);
                    e   = leaf_words[pos];
                    // an all-zero leaf word counts as not mapped
                    if (e != '0) begin
                        r.found       = 1'b1;
                        r.mapped_addr = {e[31:12], 12'h000};
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        n_errors++;
    endtask

    task automatic push_cmd(tlpt_pkg::t_mode m, logic [31:0] va, logic [31:0] pa,
                            logic [11:0] fl, bit drain = 1'b0);
        t_walk_cmd c;
        c.mode  = m;
        c.va    = va;
        c.pa    = pa;
        c.flags = fl;
        c.drain = drain;
        cmd_q.push_back(c);
    endtask

    // ---------------------------------------------------------------
    // driver: one transaction is taken at an edge with start high, busy low
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : drive_proc
        bit        gap;
        bit        hold;
        t_walk_cmd c;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && busy === 1'b0) begin
                walk_results_q.push_back(walk_table(i_mode, i_virt_addr,
                                                    i_phys_addr, i_entry_flags));
            end
            // the command lines are free once nothing is waiting on them
            if (!start || busy === 1'b0) begin
                gap  = (n_issued < QUIET_FIRST || n_issued >= QUIET_LAST) &&
                       ($urandom_range(99) < IDLE_PCT);
                hold = cmd_q.size() != 0 && cmd_q[0].drain &&
                       walk_results_q.size() != 0;
                if (cmd_q.size() != 0 && !gap && !hold) begin
                    c = cmd_q.pop_front();
                    start         <= 1'b1;
                    i_mode        <= c.mode;
                    i_virt_addr   <= c.va;
                    i_phys_addr   <= c.pa;
                    i_entry_flags <= c.flags;
                    n_issued++;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: results last one cycle and cannot be held off
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : watch_proc
        t_walk_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (walk_results_q.size() == 0) begin
                report_mismatch("result with no command outstanding");
            end else begin
                want = walk_results_q.pop_front();
                if (o_found !== want.found)
                    report_mismatch($sformatf("found %b, expected %b",
                                              o_found, want.found));
                if (o_mapped_addr !== want.mapped_addr)
                    report_mismatch($sformatf("mapped_addr %h, expected %h",
                                              o_mapped_addr, want.mapped_addr));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %b, expected %b",
                                              o_status, want.status));
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus and end of run
    // ---------------------------------------------------------------
    initial begin : stim_proc
        logic [9:0]      dir_pick  [DIR_POOL];
        logic [9:0]      leaf_pick [LEAF_POOL];
        int              roll;
        tlpt_pkg::t_mode m;
        logic [31:0]     va;
        logic [31:0]     pa;
        logic [11:0]     fl;

        // directory and leaf indices reused often, so maps get looked up again
        dir_pick[0] = 10'd0;
        dir_pick[1] = 10'h3FF;
        for (int k = 2; k < DIR_POOL; k++) dir_pick[k] = 10'($urandom_range(1023));
        leaf_pick[0] = 10'd0;
        leaf_pick[1] = 10'h3FF;
        for (int k = 2; k < LEAF_POOL; k++) leaf_pick[k] = 10'($urandom_range(1023));

        // directed: empty tables, reserved mode, extremes, zero leaf value
        push_cmd(tlpt_pkg::MODE_LOOKUP, 32'h0000_0000, 32'h0, 12'h000);
        push_cmd(tlpt_pkg::MODE_UNMAP, 32'h0000_0000, 32'h0, 12'h000);
        push_cmd(MODE_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
        push_cmd(tlpt_pkg::MODE_MAP, 32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
        push_cmd(tlpt_pkg::MODE_LOOKUP, 32'h0000_0000, 32'h0, 12'h000);
        push_cmd(tlpt_pkg::MODE_MAP, 32'h0000_1000, 32'h0000_0FFF, 12'h000);
        push_cmd(tlpt_pkg::MODE_LOOKUP, 32'h0000_1000, 32'h0, 12'h000);
        push_cmd(tlpt_pkg::MODE_MAP, 32'hFFFF_FFFF, 32'h1234_5678, 12'h000);
        push_cmd(tlpt_pkg::MODE_LOOKUP, 32'hFFFF_F000, 32'hFFFF_FFFF, 12'hFFF);
        // flags only: found with a zero frame address
        push_cmd(tlpt_pkg::MODE_MAP, 32'h0000_2000, 32'h0000_0000, 12'h001);
        push_cmd(tlpt_pkg::MODE_LOOKUP, 32'h0000_2ABC, 32'h0, 12'h000);
        push_cmd(tlpt_pkg::MODE_UNMAP, 32'h0000_0FFF, 32'hFFFF_FFFF, 12'hFFF);
        push_cmd(tlpt_pkg::MODE_LOOKUP, 32'h0000_0000, 32'h0, 12'h000);
        push_cmd(tlpt_pkg::MODE_UNMAP, 32'hFFFF_FFFF, 32'h0, 12'h000);
        push_cmd(tlpt_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0, 12'h000);
        // unmap and lookup on a directory entry that was never mapped
        push_cmd(tlpt_pkg::MODE_UNMAP, 32'h8000_0000, 32'h0, 12'h000);
        push_cmd(tlpt_pkg::MODE_LOOKUP, 32'h8000_0000, 32'h0, 12'h000);
        push_cmd(tlpt_pkg::MODE_MAP, 32'h0000_0000, 32'hABCD_E123, 12'h5A5);
        push_cmd(tlpt_pkg::MODE_LOOKUP, 32'h0000_0FFF, 32'h0, 12'h000);
        push_cmd(MODE_RESERVED, 32'h0000_0000, 32'h0, 12'h000);
        push_cmd(tlpt_pkg::MODE_LOOKUP, 32'h0000_0000, 32'h0, 12'h000, 1'b1);

        // random: mostly pooled addresses so the slot pool runs out early
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(99);
            if (roll < 35)      m = tlpt_pkg::MODE_MAP;
            else if (roll < 50) m = tlpt_pkg::MODE_UNMAP;
            else if (roll < 95) m = tlpt_pkg::MODE_LOOKUP;
            else                m = MODE_RESERVED;
            if ($urandom_range(99) < 85)
                va = {dir_pick[$urandom_range(DIR_POOL - 1)],
                      leaf_pick[$urandom_range(LEAF_POOL - 1)],
                      12'($urandom_range(4095))};
            else
                va = $urandom;
            pa = ($urandom_range(99) < 8) ? 32'h0 : $urandom;
            fl = ($urandom_range(99) < 8) ? 12'h000 : 12'($urandom_range(4095));
            push_cmd(m, va, pa, fl, (n % DRAIN_EVERY) == DRAIN_EVERY - 1);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_q.size() != 0 || start) @(posedge i_clk);
        while (walk_results_q.size() != 0) @(posedge i_clk);
        // any late or extra result would show up in this window
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (walk_results_q.size() != 0)
            report_mismatch($sformatf("%0d results never came",
                                      walk_results_q.size()));

        if (n_errors == 0) begin
            $display("** two_level_page_table_engine: PASSED **");
        end else begin
            $display("** two_level_page_table_engine: FAILED **");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #2_000_000;
        $display("** two_level_page_table_engine: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
sv/tlpt_pkg.sv
sv/tlpt_ram.sv
sv/tlpt_ctrl.sv
sv/two_level_page_table_engine.sv
sv/tlpt_checker.sv
dv/tb_top.sv
